@@ design/krt_pkg.sv @@
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants of the keyed record table
// Field widths, operation and status codes, and the record type held by
// every table cell.
// ----------------------------------------------------------------------------
package krt_pkg;

  // Default number of table cells.
  localparam int DEPTH_DEF = 64;

  // Field widths of the item formats.
  localparam int MODE_W = 2;
  localparam int KEY_W  = 32;
  localparam int AMT_W  = 31;
  localparam int GRP_W  = 16;
  localparam int POS_W  = 6;
  localparam int STAT_W = 3;
  localparam int FILL_W = 7;

  // Operation codes carried in the input tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 2'd0,
    MODE_UPD = 2'd1,
    MODE_DEL = 2'd2,
    MODE_RD  = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_BADPOS  = 3'd4
  } status_t;

  // One table record.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
    logic [GRP_W-1:0] group;
  } rec_t;

  // Per-cell write controls for the commit cycle.
  typedef struct packed {
    logic load_rec;   // store a whole new record
    logic load_pay;   // rewrite the two payload words only
    logic take_next;  // copy the right-hand neighbor's record
  } cell_ctl_t;

  // Search broadcast to every cell when an item is accepted.
  typedef struct packed {
    logic             cap;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } srch_t;

endpackage

@@ design/krt_cell.sv @@
// ----------------------------------------------------------------------------
// krt_cell: one table cell
// Holds one record, compares it against the broadcast search key and
// position, and loads, rewrites or takes its neighbor's record on commit.
// ----------------------------------------------------------------------------
module krt_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  krt_pkg::srch_t    srch,
  input  logic              vld,
  input  krt_pkg::cell_ctl_t ctl,
  input  krt_pkg::rec_t     wr_rec,
  input  krt_pkg::rec_t     nbr_rec,
  output krt_pkg::rec_t     rec_r,
  output logic              match_r,
  output logic              sel_r
);

  krt_pkg::rec_t rec_nxt;
  logic          match_nxt;
  logic          sel_nxt;

  // Compare results are captured when an item is taken in.
  always_comb begin
    match_nxt = match_r;
    sel_nxt   = sel_r;
    if (srch.cap) begin
      match_nxt = vld && (rec_r.key == srch.key);
      sel_nxt   = (32'(IDX) == 32'(srch.pos));
    end
  end

  // Record update: append, payload rewrite or shift down for a delete.
  always_comb begin
    rec_nxt = rec_r;
    if (ctl.load_rec) begin
      rec_nxt = wr_rec;
    end else if (ctl.load_pay) begin
      rec_nxt.amount = wr_rec.amount;
      rec_nxt.group  = wr_rec.group;
    end else if (ctl.take_next) begin
      rec_nxt = nbr_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r   <= rec_nxt;
    match_r <= match_nxt;
    sel_r   <= sel_nxt;
  end

endmodule

@@ design/krt_hit.sv @@
// ----------------------------------------------------------------------------
// krt_hit: first-match resolver
// Turns the registered match vector of the cells into a one-hot mark of the
// lowest matching cell and a mask of that cell and all cells above it.
// ----------------------------------------------------------------------------
module krt_hit #(
  parameter int N = krt_pkg::DEPTH_DEF
) (
  input  logic [N-1:0] match,
  output logic [N-1:0] hit_oh,
  output logic [N-1:0] tail_mask,
  output logic         found
);

  // Lowest set bit isolated by a two's complement add.
  assign hit_oh    = match & (~match + N'(1));
  // Cells at or above the hit; empty when there is no hit.
  assign tail_mask = ~(hit_oh - N'(1));
  assign found     = |match;

endmodule

@@ design/keyed_record_table.sv @@
// ----------------------------------------------------------------------------
// keyed_record_table: ordered table of keyed records
// Add, update by key, delete by key and read by position over a chain of
// record cells, one result item per input item.
// ----------------------------------------------------------------------------
// Every item passes through an accept cycle and a commit cycle: in the
// accept cycle each of the TABLE_DEPTH cells compares its key with the
// search key and its index with the read position at once; in the commit
// cycle the first match is resolved, the cells are written (a delete
// shifts every cell above the hit down by one in that same cycle) and the
// result is loaded into the output register. The input is ready again
// right after, so a new item is taken while the previous result still
// waits; if that result is not yet taken when the commit cycle comes, the
// commit waits for the output register to free up. No new item is taken
// before the last one commits. The first key handed out after reset is 1.
// ----------------------------------------------------------------------------
module keyed_record_table #(
  parameter int TABLE_DEPTH = krt_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // key[31:0], pay_amount[62:32], group_code[78:63],
                                  // position[84:79], zero fill
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata   // status[2:0], out_key[34:3], out_amount[65:35],
                                  // out_group[81:66], fill_count[88:82], zero fill
);

  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int RW  = $bits(krt_pkg::rec_t);
  localparam int OW  = krt_pkg::STAT_W + krt_pkg::KEY_W + krt_pkg::AMT_W +
                       krt_pkg::GRP_W + krt_pkg::FILL_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [krt_pkg::KEY_W-1:0]  kc_r, kc_nxt;
  krt_pkg::mode_t             mode_r;
  logic [krt_pkg::AMT_W-1:0]  amt_r;
  logic [krt_pkg::GRP_W-1:0]  grp_r;
  logic [krt_pkg::POS_W-1:0]  pos_r;
  logic                       out_vld_r, out_vld_nxt;
  logic [OW-1:0]              out_dat_r, out_dat_nxt;

  logic                       accept;
  logic                       commit;
  logic                       full;
  krt_pkg::srch_t             srch;
  krt_pkg::rec_t              wr_rec;
  krt_pkg::rec_t              rec_q [TABLE_DEPTH];
  krt_pkg::cell_ctl_t         ctl   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]     vld;
  logic [TABLE_DEPTH-1:0]     match_q;
  logic [TABLE_DEPTH-1:0]     sel_q;
  logic [TABLE_DEPTH-1:0]     hit_oh;
  logic [TABLE_DEPTH-1:0]     tail_mask;
  logic                       found;
  logic [RW-1:0]              rd_bits;
  krt_pkg::rec_t              rd_rec;
  krt_pkg::status_t           st;
  logic [krt_pkg::KEY_W-1:0]  o_key;
  logic [krt_pkg::AMT_W-1:0]  o_amt;
  logic [krt_pkg::GRP_W-1:0]  o_grp;

  // Handshake.
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign commit    = (state_r == S_EXEC) && (!out_vld_r || out_tready);
  assign full      = (32'(count_r) >= 32'(TABLE_DEPTH));

  assign srch.cap = accept;
  assign srch.key = in_tdata[31:0];
  assign srch.pos = in_tdata[84:79];

  // Record written by an add; update uses its payload words only.
  assign wr_rec.key    = kc_r + krt_pkg::KEY_W'(1);
  assign wr_rec.amount = amt_r;
  assign wr_rec.group  = grp_r;

  // Cell chain.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    krt_pkg::rec_t nbr;

    if (i == TABLE_DEPTH - 1) begin : g_end
      assign nbr = rec_q[i];
    end else begin : g_mid
      assign nbr = rec_q[i+1];
    end

    assign vld[i] = (CW'(i) < count_r);

    always_comb begin
      ctl[i].load_rec  = commit && (mode_r == krt_pkg::MODE_ADD) && !full &&
                         (count_r == CW'(i));
      ctl[i].load_pay  = commit && (mode_r == krt_pkg::MODE_UPD) && hit_oh[i];
      ctl[i].take_next = commit && (mode_r == krt_pkg::MODE_DEL) && tail_mask[i];
    end

    krt_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .srch    (srch),
      .vld     (vld[i]),
      .ctl     (ctl[i]),
      .wr_rec  (wr_rec),
      .nbr_rec (nbr),
      .rec_r   (rec_q[i]),
      .match_r (match_q[i]),
      .sel_r   (sel_q[i])
    );
  end

  krt_hit #(
    .N (TABLE_DEPTH)
  ) u_hit (
    .match     (match_q),
    .hit_oh    (hit_oh),
    .tail_mask (tail_mask),
    .found     (found)
  );

  // Read port: AND-OR over the cells marked by the position compare.
  always_comb begin
    rd_bits = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      rd_bits = rd_bits | (rec_q[i] & {RW{sel_q[i]}});
    end
  end
  assign rd_rec = krt_pkg::rec_t'(rd_bits);

  // Result and state updates of the commit cycle.
  always_comb begin
    st        = krt_pkg::ST_OK;
    o_key     = '0;
    o_amt     = '0;
    o_grp     = '0;
    count_nxt = count_r;
    kc_nxt    = kc_r;
    case (mode_r)
      krt_pkg::MODE_ADD: begin
        if (full) begin
          st = krt_pkg::ST_FULL;
        end else begin
          o_key = wr_rec.key;
          if (commit) begin
            kc_nxt    = wr_rec.key;
            count_nxt = count_r + CW'(1);
          end
        end
      end
      krt_pkg::MODE_UPD: begin
        if (!found) begin
          st = krt_pkg::ST_UNKNOWN;
        end
      end
      krt_pkg::MODE_DEL: begin
        if (count_r == '0) begin
          st = krt_pkg::ST_EMPTY;
        end else if (!found) begin
          st = krt_pkg::ST_UNKNOWN;
        end else if (commit) begin
          count_nxt = count_r - CW'(1);
        end
      end
      krt_pkg::MODE_RD: begin
        if (32'(pos_r) >= 32'(count_r)) begin
          st = krt_pkg::ST_BADPOS;
        end else begin
          o_key = rd_rec.key;
          o_amt = rd_rec.amount;
          o_grp = rd_rec.group;
        end
      end
      default: begin
        st = krt_pkg::ST_OK;
      end
    endcase
  end

  // Sequencer and output register.
  always_comb begin
    state_nxt   = state_r;
    out_vld_nxt = out_vld_r;
    out_dat_nxt = out_dat_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (commit) begin
      out_vld_nxt = 1'b1;
      out_dat_nxt = {krt_pkg::FILL_W'(count_nxt), o_grp, o_amt, o_key, st};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      kc_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      kc_r      <= kc_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Operation fields held for the commit cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= krt_pkg::mode_t'(in_tuser);
      amt_r  <= in_tdata[62:32];
      grp_r  <= in_tdata[78:63];
      pos_r  <= in_tdata[84:79];
    end
    out_dat_r <= out_dat_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(96 - OW)'(0), out_dat_r};

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(TABLE_DEPTH))
    else $error("fill count above table depth");

  // At most one cell is marked as the first match.
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(hit_oh))
    else $error("first-match mark not one-hot");

  // A stalled commit leaves the table size alone.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && out_vld_r && !out_tready) |=> $stable(count_r))
    else $error("table changed while result stalled");

  // A committed add to a table with room grows it by one.
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && mode_r == krt_pkg::MODE_ADD && !full) |=>
      (count_r == CW'($past(count_r) + CW'(1))))
    else $error("add did not grow the table");

  // An accepted item always moves to the commit cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted item not executed");

endmodule
